@@ hw/rtl/tcb_pkg.sv @@
// Shared constants, register codes and data types of the timed crossfade blend.
`default_nettype none

package tcb_pkg;

  // Fade fraction resolution: one is 2**FRAC_W
  localparam int unsigned FRAC_W       = 14;
  localparam int unsigned FRAC_ONE     = 1 << FRAC_W;
  localparam int unsigned FRAC_ONE_W   = FRAC_W + 1;
  localparam int unsigned MAX_ELEMENTS = 4096;

  localparam int unsigned ELAPSED_W  = 31;
  localparam int unsigned DUR_W      = 24;
  localparam int unsigned ALPHA_W    = 15;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Start-to-result path: front, queue, divider stages, four blend stages, output
  localparam int unsigned LATENCY = FRAC_W + 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DURATION = 3'd0,
    REG_ALPHA    = 3'd1,
    REG_START    = 3'd2,
    REG_COUNT    = 3'd3,
    REG_LENGTH   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [DUR_W-1:0]   duration;
    logic [ALPHA_W-1:0] alpha;
    logic [IDX_W-1:0]   start;
    logic [LEN_W-1:0]   count;
    logic [LEN_W-1:0]   length;
  } cfg_t;

  // Classified item as it travels from the front to the back
  typedef struct packed {
    logic [DUR_W-1:0]  elapsed;
    logic              done;
    logic              written;
    logic [DATA_W-1:0] bg;
    logic [DATA_W-1:0] fg;
  } item_t;

endpackage

`default_nettype wire

@@ hw/rtl/timed_crossfade_blend_top.sv @@
// Timed crossfade blend: top level joining registers, front, queue and back.
//
// Usage:
//   Command channel: drive elapsed_ms_i, offset_i, background_i and
//   foreground_i with start_i high; the command is taken at the clock edge
//   where start_i is high and busy_o is low. One command per cycle is taken while busy_o is low.
//   Result channel: result_valid_o is high for one cycle with blended_o,
//   written_o and fade_done_o. A taken command passes the front register,
//   the queue, one divider stage per fraction bit, four blend stages and the
//   output register. Results leave in command order, one per cycle at most,
//   sustaining one item per cycle.
//   The fade fraction divider is a pipeline, so busy_o only rises if the
//   queue ever fills; with a streaming back end it stays low.
//   Configuration: cfg_valid_i / cfg_ready_o transfer cfg_data_i into the
//   register cfg_index_i (duration, alpha, start, count, length); write only
//   while no command is in flight. cfg_ready_o is always high.
//   Reset (rst_ni low) empties the pipeline and queue and restores register
//   defaults. The receiver cannot stall; results are never held back.
`default_nettype none

module timed_crossfade_blend_top
  import tcb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ELAPSED_W-1:0]  elapsed_ms_i,
  input  logic [IDX_W-1:0]      offset_i,
  input  logic [DATA_W-1:0]     background_i,
  input  logic [DATA_W-1:0]     foreground_i,
  output logic                  result_valid_o,
  output logic [DATA_W-1:0]     blended_o,
  output logic                  written_o,
  output logic                  fade_done_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg;
  item_t front_item;
  item_t head_item;
  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;

  tcb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tcb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .elapsed_ms_i (elapsed_ms_i),
    .offset_i     (offset_i),
    .background_i (background_i),
    .foreground_i (foreground_i),
    .cfg_i        (cfg),
    .full_i       (q_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  tcb_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tcb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (~q_empty),
    .item_i         (head_item),
    .pop_o          (pop),
    .duration_i     (cfg.duration),
    .alpha_i        (cfg.alpha),
    .result_valid_o (result_valid_o),
    .blended_o      (blended_o),
    .written_o      (written_o),
    .fade_done_o    (fade_done_o)
  );

  // Every taken command yields its result at the end of the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY result_valid_o)
    else $error("result missing after accepted command");

  // No result appears without a matching taken command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without matching command");

  // The back end drains one item per cycle, so the queue never backs up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("queue backed up against the front");

endmodule

`default_nettype wire

@@ hw/rtl/tcb_regs.sv @@
// Configuration register file of the timed crossfade blend.
`default_nettype none

module tcb_regs
  import tcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DURATION: cfg_d.duration = cfg_data_i[DUR_W-1:0];
        REG_ALPHA:    cfg_d.alpha    = cfg_data_i[ALPHA_W-1:0];
        REG_START:    cfg_d.start    = cfg_data_i[IDX_W-1:0];
        REG_COUNT:    cfg_d.count    = cfg_data_i[LEN_W-1:0];
        REG_LENGTH:   cfg_d.length   = cfg_data_i[LEN_W-1:0];
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duration <= '0;
      cfg_q.alpha    <= ALPHA_W'(FRAC_ONE);
      cfg_q.start    <= '0;
      cfg_q.count    <= '0;
      cfg_q.length   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/tcb_front.sv @@
// Front end: takes commands, decides fade done and bounds, registers the item.
`default_nettype none

module tcb_front
  import tcb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [ELAPSED_W-1:0] elapsed_ms_i,
  input  logic [IDX_W-1:0]     offset_i,
  input  logic [DATA_W-1:0]    background_i,
  input  logic [DATA_W-1:0]    foreground_i,
  input  cfg_t                 cfg_i,
  input  logic                 full_i,
  output logic                 push_o,
  output item_t                item_o
);

  logic             valid_q, valid_d;
  item_t            item_q, item_d;
  logic             load;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] abs_index;

  assign busy_o = valid_q & full_i;
  assign push_o = valid_q & ~full_i;
  assign load   = start_i & ~busy_o;

  assign limit     = (cfg_i.length > LEN_W'(MAX_ELEMENTS)) ? LEN_W'(MAX_ELEMENTS) : cfg_i.length;
  assign abs_index = LEN_W'(cfg_i.start) + LEN_W'(offset_i);

  always_comb begin
    item_d.elapsed = elapsed_ms_i[DUR_W-1:0];
    item_d.done    = (elapsed_ms_i >= ELAPSED_W'(cfg_i.duration));
    item_d.written = (LEN_W'(offset_i) < cfg_i.count) && (abs_index < limit);
    item_d.bg      = background_i;
    item_d.fg      = foreground_i;
  end

  // Hold the item while the queue is full
  assign valid_d = load | (valid_q & full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

@@ hw/rtl/tcb_queue.sv @@
// Small FIFO of classified items between the front and the back.
`default_nettype none

module tcb_queue
  import tcb_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ hw/rtl/tcb_back.sv @@
// Back end: pipelined fade-fraction divider, opacity scaling and blend.
`default_nettype none

module tcb_back
  import tcb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  item_t              item_i,
  output logic               pop_o,
  input  logic [DUR_W-1:0]   duration_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  output logic               result_valid_o,
  output logic [DATA_W-1:0]  blended_o,
  output logic               written_o,
  output logic               fade_done_o
);

  localparam int unsigned SCALE_W = FRAC_ONE_W + ALPHA_W;
  localparam int unsigned PROD_W  = DATA_W + FRAC_ONE_W;
  localparam int unsigned SUM_W   = PROD_W + 1;

  // The pipeline never stalls: take the queue head whenever there is one
  assign pop_o = valid_i;

  // Restoring divider: elapsed * FRAC_ONE / duration, one quotient bit per stage
  logic                     div_vld_q  [FRAC_W];
  logic [DUR_W-1:0]         div_rem_q  [FRAC_W];
  logic [FRAC_W-1:0]        div_quo_q  [FRAC_W];
  logic                     div_done_q [FRAC_W];
  logic                     div_wr_q   [FRAC_W];
  logic signed [DATA_W-1:0] div_bg_q   [FRAC_W];
  logic signed [DATA_W-1:0] div_fg_q   [FRAC_W];

  for (genvar k = 0; k < FRAC_W; k++) begin : g_div
    logic                     vld_in;
    logic [DUR_W-1:0]         rem_in;
    logic [FRAC_W-1:0]        quo_in;
    logic                     done_in;
    logic                     wr_in;
    logic signed [DATA_W-1:0] bg_in;
    logic signed [DATA_W-1:0] fg_in;
    logic [DUR_W:0]           trial;
    logic                     ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = item_i.elapsed;
      assign quo_in  = '0;
      assign done_in = item_i.done;
      assign wr_in   = item_i.written;
      assign bg_in   = $signed(item_i.bg);
      assign fg_in   = $signed(item_i.fg);
    end else begin : g_next
      assign vld_in  = div_vld_q[k-1];
      assign rem_in  = div_rem_q[k-1];
      assign quo_in  = div_quo_q[k-1];
      assign done_in = div_done_q[k-1];
      assign wr_in   = div_wr_q[k-1];
      assign bg_in   = div_bg_q[k-1];
      assign fg_in   = div_fg_q[k-1];
    end

    assign trial = {rem_in, 1'b0};
    assign ge    = (trial >= {1'b0, duration_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[k] <= 1'b0;
      end else begin
        div_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      div_rem_q[k]  <= ge ? DUR_W'(trial - {1'b0, duration_i}) : trial[DUR_W-1:0];
      div_quo_q[k]  <= {quo_in[FRAC_W-2:0], ge};
      div_done_q[k] <= done_in;
      div_wr_q[k]   <= wr_in;
      div_bg_q[k]   <= bg_in;
      div_fg_q[k]   <= fg_in;
    end
  end

  // Stage A: pick the raw fraction and scale it by the opacity
  logic                     a_vld_q;
  logic [SCALE_W-1:0]       a_prod_q;
  logic                     a_done_q, a_wr_q;
  logic signed [DATA_W-1:0] a_bg_q, a_fg_q;
  logic [FRAC_ONE_W-1:0]    a_frac;

  assign a_frac = div_done_q[FRAC_W-1] ? FRAC_ONE_W'(FRAC_ONE)
                                       : FRAC_ONE_W'(div_quo_q[FRAC_W-1]);

  // Stage B: drop the scale and saturate to one
  logic                     b_vld_q;
  logic [FRAC_ONE_W-1:0]    b_fg_w_q, b_bg_w_q;
  logic                     b_done_q, b_wr_q;
  logic signed [DATA_W-1:0] b_bg_q, b_fg_q;
  logic [SCALE_W-FRAC_W-1:0] b_shifted;
  logic [FRAC_ONE_W-1:0]    b_frac;

  assign b_shifted = a_prod_q[SCALE_W-1:FRAC_W];
  assign b_frac    = (b_shifted > (SCALE_W - FRAC_W)'(FRAC_ONE)) ? FRAC_ONE_W'(FRAC_ONE)
                                                                 : FRAC_ONE_W'(b_shifted);

  // Stage C: weight both layers
  logic                     c_vld_q;
  logic signed [PROD_W-1:0] c_bg_p_q, c_fg_p_q;
  logic                     c_done_q, c_wr_q;
  logic signed [DATA_W-1:0] c_bg_q;

  // Stage D: sum of weighted layers
  logic                     d_vld_q;
  logic signed [SUM_W-1:0]  d_sum_q;
  logic                     d_done_q, d_wr_q;
  logic signed [DATA_W-1:0] d_bg_q;

  // Output stage: divide by one fraction unit, truncating toward zero; unwritten items pass the background
  logic [SUM_W-1:0] bias;
  logic [SUM_W-1:0] biased;

  assign bias   = d_sum_q[SUM_W-1] ? SUM_W'(FRAC_ONE - 1) : '0;
  assign biased = d_sum_q + bias;

  logic              out_vld_q;
  logic [DATA_W-1:0] out_blended_q;
  logic              out_wr_q, out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      a_vld_q   <= div_vld_q[FRAC_W-1];
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      out_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_prod_q <= SCALE_W'(a_frac) * SCALE_W'(alpha_i);
    a_done_q <= div_done_q[FRAC_W-1];
    a_wr_q   <= div_wr_q[FRAC_W-1];
    a_bg_q   <= div_bg_q[FRAC_W-1];
    a_fg_q   <= div_fg_q[FRAC_W-1];

    b_fg_w_q <= b_frac;
    b_bg_w_q <= FRAC_ONE_W'(FRAC_ONE) - b_frac;
    b_done_q <= a_done_q;
    b_wr_q   <= a_wr_q;
    b_bg_q   <= a_bg_q;
    b_fg_q   <= a_fg_q;

    c_bg_p_q <= PROD_W'(b_bg_q) * PROD_W'(signed'({1'b0, b_bg_w_q}));
    c_fg_p_q <= PROD_W'(b_fg_q) * PROD_W'(signed'({1'b0, b_fg_w_q}));
    c_done_q <= b_done_q;
    c_wr_q   <= b_wr_q;
    c_bg_q   <= b_bg_q;

    d_sum_q  <= SUM_W'(c_bg_p_q) + SUM_W'(c_fg_p_q);
    d_done_q <= c_done_q;
    d_wr_q   <= c_wr_q;
    d_bg_q   <= c_bg_q;

    out_blended_q <= d_wr_q ? biased[FRAC_W +: DATA_W] : d_bg_q;
    out_wr_q      <= d_wr_q;
    out_done_q    <= d_done_q;
  end

  assign result_valid_o = out_vld_q;
  assign blended_o      = out_blended_q;
  assign written_o      = out_wr_q;
  assign fade_done_o    = out_done_q;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the timed crossfade blend: random and directed commands, predicted results.
module testbench
  import tcb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic [IDX_W-1:0]     offset;
    logic [DATA_W-1:0]    bg;
    logic [DATA_W-1:0]    fg;
  } blend_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] blended;
    logic              written;
    logic              done;
  } blend_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [ELAPSED_W-1:0]  elapsed_ms_i = '0;
  logic [IDX_W-1:0]      offset_i = '0;
  logic [DATA_W-1:0]     background_i = '0;
  logic [DATA_W-1:0]     foreground_i = '0;
  logic                  result_valid_o;
  logic [DATA_W-1:0]     blended_o;
  logic                  written_o;
  logic                  fade_done_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Register copies used by the blend predictor
  logic [DUR_W-1:0]   cfg_duration = '0;
  logic [ALPHA_W-1:0] cfg_alpha = ALPHA_W'(FRAC_ONE);
  logic [IDX_W-1:0]   cfg_first = '0;
  logic [LEN_W-1:0]   cfg_count = '0;
  logic [LEN_W-1:0]   cfg_length = '0;

  blend_cmd_t  pending_cmds[$];
  blend_res_t  expected_blends[$];
  int unsigned cmds_issued = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned sender_idle_pct = 28;

  timed_crossfade_blend_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .elapsed_ms_i   (elapsed_ms_i),
    .offset_i       (offset_i),
    .background_i   (background_i),
    .foreground_i   (foreground_i),
    .result_valid_o (result_valid_o),
    .blended_o      (blended_o),
    .written_o      (written_o),
    .fade_done_o    (fade_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic blend_res_t predict_blend(input blend_cmd_t c);
    longint unsigned frac;
    longint unsigned lim;
    longint signed   f;
    longint signed   bgv;
    longint signed   fgv;
    longint signed   acc;
    blend_res_t      r;
    if (longint'(c.elapsed) >= longint'(cfg_duration)) begin
      r.done = 1'b1;
      frac = 64'(FRAC_ONE);
    end else begin
      r.done = 1'b0;
      frac = (longint'(c.elapsed) * FRAC_ONE) / longint'(cfg_duration);
    end
    // scale by opacity, saturate at one
    frac = (frac * cfg_alpha) / FRAC_ONE;
    if (frac > FRAC_ONE) frac = 64'(FRAC_ONE);
    lim = (cfg_length > MAX_ELEMENTS) ? 64'(MAX_ELEMENTS) : 64'(cfg_length);
    r.written = (c.offset < cfg_count) &&
                (longint'(cfg_first) + longint'(c.offset) < lim);
    bgv = $signed(c.bg);
    fgv = $signed(c.fg);
    if (r.written) begin
      f = longint'(frac);
      acc = bgv * (longint'(FRAC_ONE) - f) + fgv * f;
      acc = acc / longint'(FRAC_ONE);
      r.blended = acc[DATA_W-1:0];
    end else begin
      r.blended = c.bg;
    end
    return r;
  endfunction

  // Driver: hold the current command until it transfers, then advance or idle
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    blend_cmd_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (start_i) begin
        expected_blends.insert(expected_blends.size(),
                               predict_blend({elapsed_ms_i, offset_i,
                                              background_i, foreground_i}));
      end
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = pending_cmds.pop_front();
        start_i      <= 1'b1;
        elapsed_ms_i <= nxt.elapsed;
        offset_i     <= nxt.offset;
        background_i <= nxt.bg;
        foreground_i <= nxt.fg;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin : check_proc
    blend_res_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_blends.size() == 0) begin
        flag_error($sformatf("unexpected result blended=%h written=%b done=%b",
                             blended_o, written_o, fade_done_o));
      end else begin
        want = expected_blends.pop_front();
        results_checked++;
        if (blended_o !== want.blended || written_o !== want.written ||
            fade_done_o !== want.done) begin
          flag_error($sformatf("blended %h/%h written %b/%b done %b/%b (exp/got)",
                               want.blended, blended_o, want.written, written_o,
                               want.done, fade_done_o));
        end
      end
    end
  end

  task automatic add_cmd(input logic [ELAPSED_W-1:0] el, input logic [IDX_W-1:0] off,
                         input logic [DATA_W-1:0] bg, input logic [DATA_W-1:0] fg);
    blend_cmd_t c;
    c = {el, off, bg, fg};
    pending_cmds.insert(pending_cmds.size(), c);
    cmds_issued++;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_cmds(input int n);
    logic [ELAPSED_W-1:0] el;
    logic [IDX_W-1:0]     off;
    int unsigned          span;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       el = '0;
        1:       el = ELAPSED_W'(cfg_duration);
        2:       el = ELAPSED_W'(cfg_duration - 1);
        7:       el = ELAPSED_W'(cfg_duration + $urandom_range(1, 5000));
        8:       el = ELAPSED_W'($urandom);
        9:       el = {ELAPSED_W{1'b1}};
        default: el = ELAPSED_W'($urandom_range(0, cfg_duration));
      endcase
      span = (cfg_count > MAX_ELEMENTS) ? MAX_ELEMENTS : cfg_count;
      if (span != 0 && $urandom_range(0, 9) < 7) off = IDX_W'($urandom_range(0, span - 1));
      else off = IDX_W'($urandom);
      add_cmd(el, off, rand_word(), rand_word());
    end
  endtask

  // Leave valid high across back-to-back writes; the caller lowers it
  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      REG_DURATION: cfg_duration = v[DUR_W-1:0];
      REG_ALPHA:    cfg_alpha    = v[ALPHA_W-1:0];
      REG_START:    cfg_first    = v[IDX_W-1:0];
      REG_COUNT:    cfg_count    = v[LEN_W-1:0];
      REG_LENGTH:   cfg_length   = v[LEN_W-1:0];
      default:      ;
    endcase
  endtask

  task automatic load_fade(input logic [DUR_W-1:0] dur, input logic [ALPHA_W-1:0] alpha,
                           input logic [IDX_W-1:0] first, input logic [LEN_W-1:0] cnt,
                           input logic [LEN_W-1:0] len);
    write_reg(REG_DURATION, CFG_DATA_W'(dur));
    write_reg(REG_ALPHA, CFG_DATA_W'(alpha));
    write_reg(REG_START, CFG_DATA_W'(first));
    write_reg(REG_COUNT, CFG_DATA_W'(cnt));
    write_reg(REG_LENGTH, CFG_DATA_W'(len));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (results_checked != cmds_issued);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: layer covers offsets 0..99, but the array ends at offset 44
    load_fade(24'd1000, 15'd16384, 12'd10, 13'd100, 13'd55);
    add_cmd(31'd0, 12'd0, 32'd1000, -32'sd1000);
    add_cmd(31'd500, 12'd1, 32'd0, 32'd16384);
    add_cmd(31'd999, 12'd2, 32'h7fff_ffff, 32'h8000_0000);
    add_cmd(31'd1000, 12'd3, 32'h8000_0000, 32'h7fff_ffff);
    add_cmd({ELAPSED_W{1'b1}}, 12'd44, 32'hffff_ffff, 32'd7);
    add_cmd(31'd250, 12'd45, 32'd123, 32'd456);
    add_cmd(31'd250, 12'd99, 32'd123, 32'd456);
    add_cmd(31'd250, 12'd100, 32'd123, 32'd456);
    add_cmd(31'd1001, 12'hfff, 32'hdead_beef, 32'd1);
    add_cmd(31'd333, 12'd20, 32'h8000_0000, 32'h8000_0000);
    add_cmd(31'd777, 12'd30, 32'h7fff_ffff, 32'h7fff_ffff);
    add_cmd(31'd1, 12'd5, -32'sd7, 32'd3);
    add_cmd(31'd999, 12'd43, 32'd5, -32'sd5);
    add_cmd(31'd600, 12'd10, 32'h5555_5555, 32'haaaa_aaaa);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      sender_idle_pct = (p < 3) ? 28 : (p < 6) ? 64 : 0;
      case (p)
        0: load_fade(24'd0, 15'd16384, 12'd0, 13'd4096, 13'd4096);
        1: load_fade(24'hff_ffff, 15'd8192, 12'hfff, 13'h1fff, 13'h1fff);
        2: load_fade(DUR_W'($urandom_range(1, 3000)), 15'h7fff, 12'd0, 13'd4096, 13'h1fff);
        3: load_fade(24'd1, 15'd0, 12'd100, 13'd0, 13'd4096);
        4: load_fade(24'd2000, 15'd16384, 12'd4000, 13'd4096, 13'd4096);
        default: load_fade(DUR_W'($urandom), ALPHA_W'($urandom_range(0, 32767)),
                           IDX_W'($urandom), LEN_W'($urandom_range(1, 4096)),
                           LEN_W'($urandom_range(0, 8191)));
      endcase
      add_random_cmds(84);
      wait_drained();
    end

    repeat (LATENCY + 4) @(posedge clk_i);
    if (error_count == 0 && expected_blends.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
